// ===== rtl/spht_pkg.sv =====
// spht_pkg: types, codes and constants shared by the stop plate hit timer.
// Used by spht_ctrl, spht_dp, stop_plate_hit_timer and spht_checker.
package spht_pkg;

	localparam int LOG_DEPTH = 128;
	localparam int LOG_AW    = $clog2(LOG_DEPTH);
	localparam int CURSOR_W  = $clog2(LOG_DEPTH + 1);
	localparam int TIME_BITS = 32;

	// split = diff / 10 by reciprocal multiply, exact for any 32-bit diff
	localparam logic [31:0] DIV_RECIP = 32'hCCCC_CCCD;
	localparam int          DIV_SHIFT = 35;
	localparam int          PROD_W    = 64;
	localparam int          SPLIT_W   = PROD_W - DIV_SHIFT;

	localparam int          SHOWN_W   = 26;
	localparam logic [SHOWN_W-1:0] SHOWN_MAX = '1;

	localparam logic [5:0] STEP_RST      = 6'd5;
	localparam logic [7:0] SENS_MAX_RST  = 8'd200;
	localparam logic [7:0] THR_START_RST = 8'd100;

	// configuration register indexes
	localparam logic [1:0] CFG_STEP      = 2'd0;
	localparam logic [1:0] CFG_SENS_MAX  = 2'd1;
	localparam logic [1:0] CFG_THR_START = 2'd2;

	// button codes, in scan priority order
	localparam logic [2:0] KEY_START = 3'd0;
	localparam logic [2:0] KEY_STOP  = 3'd1;
	localparam logic [2:0] KEY_FWD   = 3'd2;
	localparam logic [2:0] KEY_BACK  = 3'd3;
	localparam logic [2:0] KEY_MORE  = 3'd4;
	localparam logic [2:0] KEY_LESS  = 3'd5;
	localparam logic [2:0] KEY_NONE  = 3'd6;

	localparam logic [2:0] SCR_NONE   = 3'd0;
	localparam logic [2:0] SCR_READY  = 3'd1;
	localparam logic [2:0] SCR_RECORD = 3'd2;
	localparam logic [2:0] SCR_REVIEW = 3'd3;
	localparam logic [2:0] SCR_SENSE  = 3'd4;

	localparam logic [1:0] LED_ORANGE = 2'd0;
	localparam logic [1:0] LED_WHITE  = 2'd1;
	localparam logic [1:0] LED_BLUE   = 2'd2;
	localparam logic [1:0] LED_GREEN  = 2'd3;

	localparam logic [1:0] RUN_IDLE   = 2'd0;
	localparam logic [1:0] RUN_TIMING = 2'd1;
	localparam logic [1:0] RUN_REVIEW = 2'd2;

	typedef enum logic [1:0] {
		SRC_ZERO  = 2'd0,
		SRC_SPLIT = 2'd1,
		SRC_READ  = 2'd2
	} shown_src_t;

	typedef struct packed {
		logic eval;   // decide on the accepted word, update state
		logic mul;    // run the divide-by-ten multiply
		logic rd;     // read the log at the cursor
		logic load;   // load the result word (and log a hit)
	} spht_cmd_t;

	typedef struct packed {
		logic need_hit;
		logic need_read;
	} spht_sts_t;

endpackage

// ===== rtl/spht_ctrl.sv =====
// spht_ctrl: sequencer for one poll word at a time and the result valid flag.
// Depends on spht_pkg; drives spht_dp through spht_cmd_t.
module spht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  spht_pkg::spht_sts_t sts,
	output spht_pkg::spht_cmd_t cmd
);

	typedef enum logic [3:0] {
		CS_WAIT = 4'b0001,
		CS_MUL  = 4'b0010,
		CS_RD   = 4'b0100,
		CS_LOAD = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        slot_free;
	logic        accept;

	assign accept    = in_valid && (state_q == CS_WAIT);
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			CS_WAIT: begin
				if (accept) begin
					cmd.eval = 1'b1;
					if (sts.need_hit)
						state_nxt = CS_MUL;
					else if (sts.need_read)
						state_nxt = CS_RD;
					else
						state_nxt = CS_LOAD;
				end
			end
			CS_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = CS_LOAD;
			end
			CS_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = CS_LOAD;
			end
			CS_LOAD: begin
				if (slot_free) begin
					cmd.load  = 1'b1;
					state_nxt = CS_WAIT;
				end
			end
			default: state_nxt = CS_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != CS_WAIT);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/spht_dp.sv =====
// spht_dp: button scan, run state, threshold, split multiply, hit log and result word.
// Depends on spht_pkg; sequenced by spht_ctrl.
module spht_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  spht_pkg::spht_cmd_t                 cmd,
	output spht_pkg::spht_sts_t                 sts,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [7:0]                          cfg_data,
	input  logic [5:0]                          button_levels,
	input  logic [9:0]                          sensor_sample,
	input  logic [spht_pkg::TIME_BITS-1:0]      time_ms,
	output logic [1:0]                          timer_state,
	output logic [1:0]                          led_color,
	output logic [2:0]                          screen,
	output logic [7:0]                          shot_number,
	output logic [spht_pkg::SHOWN_W-1:0]        shown_time_cs,
	output logic [7:0]                          threshold,
	output logic                                hit_flag,
	output logic                                log_full
);

	localparam int CW = spht_pkg::CURSOR_W;

	// configuration
	logic [5:0] step_q;
	logic [7:0] sens_max_q;

	// state
	logic [5:0]                        marks_q;
	logic [1:0]                        run_q;
	logic [spht_pkg::TIME_BITS-1:0]    start_q;
	logic                              has_hit_q;
	logic [CW-1:0]                     cursor_q;
	logic [CW-1:0]                     total_q;
	logic                              lamp_q;
	logic [7:0]                        thr_q;

	// per-word results
	logic [2:0]                        scr_q;
	logic                              hit_q;
	logic                              full_q;
	spht_pkg::shown_src_t              src_q;
	logic [spht_pkg::TIME_BITS-1:0]    diff_q;
	logic [spht_pkg::PROD_W-1:0]       prod_q;
	logic [spht_pkg::SPLIT_W-1:0]      rd_q;
	logic [spht_pkg::SPLIT_W-1:0]      log_mem [spht_pkg::LOG_DEPTH];

	// next values from the decision
	logic [5:0]                        marks_n;
	logic [2:0]                        btn;
	logic [1:0]                        run_n;
	logic [spht_pkg::TIME_BITS-1:0]    start_n;
	logic                              has_hit_n;
	logic [CW-1:0]                     cursor_n;
	logic [CW-1:0]                     total_n;
	logic                              lamp_n;
	logic [7:0]                        thr_n;
	logic [2:0]                        scr_n;
	logic                              hit_n;
	logic                              full_n;
	spht_pkg::shown_src_t              src_n;

	logic [CW-1:0]                     cur_m1;
	logic [spht_pkg::LOG_AW-1:0]       log_idx;
	logic [spht_pkg::SPLIT_W-1:0]      split;
	logic [spht_pkg::SPLIT_W-1:0]      shown_raw;
	logic [spht_pkg::SHOWN_W-1:0]      shown_sat;
	logic [1:0]                        led_n;

	// priority scan: stop at the first release, later marks untouched
	always_comb begin
		logic found;
		found   = 1'b0;
		marks_n = marks_q;
		btn     = spht_pkg::KEY_NONE;
		for (int i = 0; i < 6; i++) begin
			if (!found) begin
				if (!button_levels[i]) begin
					marks_n[i] = 1'b1;
				end else if (marks_q[i]) begin
					marks_n[i] = 1'b0;
					btn        = 3'(i);
					found      = 1'b1;
				end
			end
		end
	end

	always_comb begin
		logic [CW-1:0] cur;
		logic [CW-1:0] view;
		logic          want_view;
		logic [8:0]    sum;
		cur       = '0;
		view      = cursor_q;
		want_view = 1'b0;
		sum       = 9'({1'b0, thr_q} + 9'(step_q));
		run_n     = run_q;
		start_n   = start_q;
		has_hit_n = has_hit_q;
		cursor_n  = cursor_q;
		total_n   = total_q;
		lamp_n    = lamp_q;
		thr_n     = thr_q;
		scr_n     = spht_pkg::SCR_NONE;
		hit_n     = 1'b0;
		full_n    = 1'b0;
		src_n     = spht_pkg::SRC_ZERO;

		case (run_q)
			spht_pkg::RUN_TIMING: begin
				if (btn == spht_pkg::KEY_STOP) begin
					if (total_q == '0 || !has_hit_q) begin
						run_n = spht_pkg::RUN_IDLE;
						scr_n = spht_pkg::SCR_READY;
					end else begin
						run_n     = spht_pkg::RUN_REVIEW;
						want_view = 1'b1;
					end
				end else if (btn == spht_pkg::KEY_NONE && sensor_sample >= {2'b00, thr_q}) begin
					// first hit of a run restarts the log
					cur = has_hit_q ? cursor_q : '0;
					if (!has_hit_q) begin
						has_hit_n = 1'b1;
						total_n   = '0;
						cursor_n  = '0;
						lamp_n    = 1'b1;
					end
					if (cur >= CW'(spht_pkg::LOG_DEPTH)) begin
						full_n = 1'b1;
					end else begin
						lamp_n   = has_hit_q ? !lamp_q : 1'b0;
						cursor_n = cur + CW'(1);
						total_n  = cur + CW'(1);
						hit_n    = 1'b1;
						scr_n    = spht_pkg::SCR_RECORD;
						src_n    = spht_pkg::SRC_SPLIT;
					end
				end
			end
			spht_pkg::RUN_REVIEW: begin
				case (btn)
					spht_pkg::KEY_START: begin
						run_n     = spht_pkg::RUN_TIMING;
						start_n   = time_ms;
						has_hit_n = 1'b0;
						scr_n     = spht_pkg::SCR_RECORD;
					end
					spht_pkg::KEY_STOP: begin
						run_n = spht_pkg::RUN_IDLE;
						scr_n = spht_pkg::SCR_READY;
					end
					spht_pkg::KEY_FWD: begin
						if (cursor_q < total_q)
							view = cursor_q + CW'(1);
						cursor_n  = view;
						want_view = 1'b1;
					end
					spht_pkg::KEY_BACK: begin
						if (cursor_q > CW'(1))
							view = cursor_q - CW'(1);
						cursor_n  = view;
						want_view = 1'b1;
					end
					spht_pkg::KEY_MORE: begin
						if (thr_q > {2'b00, step_q})
							thr_n = thr_q - {2'b00, step_q};
						scr_n = spht_pkg::SCR_SENSE;
					end
					spht_pkg::KEY_LESS: begin
						if (thr_q < sens_max_q)
							thr_n = (sum > {1'b0, sens_max_q}) ? sens_max_q : sum[7:0];
						scr_n = spht_pkg::SCR_SENSE;
					end
					default: ;
				endcase
			end
			default: begin
				// idle, and the unused code acts as idle
				case (btn)
					spht_pkg::KEY_START: begin
						run_n     = spht_pkg::RUN_TIMING;
						start_n   = time_ms;
						has_hit_n = 1'b0;
						scr_n     = spht_pkg::SCR_RECORD;
					end
					spht_pkg::KEY_STOP: begin
						run_n     = spht_pkg::RUN_REVIEW;
						want_view = 1'b1;
					end
					spht_pkg::KEY_MORE: begin
						if (thr_q > {2'b00, step_q})
							thr_n = thr_q - {2'b00, step_q};
						scr_n = spht_pkg::SCR_SENSE;
					end
					spht_pkg::KEY_LESS: begin
						if (thr_q < sens_max_q)
							thr_n = (sum > {1'b0, sens_max_q}) ? sens_max_q : sum[7:0];
						scr_n = spht_pkg::SCR_SENSE;
					end
					default: ;
				endcase
			end
		endcase

		// review screen; empty log shows ready
		if (want_view) begin
			if (total_q == '0) begin
				scr_n = spht_pkg::SCR_READY;
			end else begin
				scr_n = spht_pkg::SCR_REVIEW;
				if (view >= CW'(1))
					src_n = spht_pkg::SRC_READ;
			end
		end
	end

	assign sts.need_hit  = hit_n;
	assign sts.need_read = (src_n == spht_pkg::SRC_READ);

	assign cur_m1  = cursor_q - CW'(1);
	assign log_idx = cur_m1[spht_pkg::LOG_AW-1:0];
	assign split   = prod_q[spht_pkg::PROD_W-1:spht_pkg::DIV_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= spht_pkg::STEP_RST;
			sens_max_q  <= spht_pkg::SENS_MAX_RST;
			marks_q     <= '0;
			run_q       <= spht_pkg::RUN_IDLE;
			start_q     <= '0;
			has_hit_q   <= 1'b0;
			cursor_q    <= '0;
			total_q     <= '0;
			lamp_q      <= 1'b0;
			thr_q       <= spht_pkg::THR_START_RST;
		end else begin
			if (cmd.eval) begin
				marks_q   <= marks_n;
				run_q     <= run_n;
				start_q   <= start_n;
				has_hit_q <= has_hit_n;
				cursor_q  <= cursor_n;
				total_q   <= total_n;
				lamp_q    <= lamp_n;
				thr_q     <= thr_n;
			end
			if (cfg_we) begin
				case (cfg_index)
					spht_pkg::CFG_STEP:      step_q <= cfg_data[5:0];
					spht_pkg::CFG_SENS_MAX:  sens_max_q <= cfg_data;
					spht_pkg::CFG_THR_START: thr_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// per-word payload, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			scr_q  <= scr_n;
			hit_q  <= hit_n;
			full_q <= full_n;
			src_q  <= src_n;
			diff_q <= time_ms - start_q;
		end
		if (cmd.mul)
			prod_q <= spht_pkg::PROD_W'(diff_q) * spht_pkg::PROD_W'(spht_pkg::DIV_RECIP);
	end

	// hit log: write on the result load, registered read
	always_ff @(posedge clk) begin
		if (cmd.load && src_q == spht_pkg::SRC_SPLIT)
			log_mem[log_idx] <= split;
		if (cmd.rd)
			rd_q <= log_mem[log_idx];
	end

	always_comb begin
		case (src_q)
			spht_pkg::SRC_SPLIT: shown_raw = split;
			spht_pkg::SRC_READ:  shown_raw = rd_q;
			default:             shown_raw = '0;
		endcase
		if (shown_raw > spht_pkg::SPLIT_W'(spht_pkg::SHOWN_MAX))
			shown_sat = spht_pkg::SHOWN_MAX;
		else
			shown_sat = shown_raw[spht_pkg::SHOWN_W-1:0];

		if (run_q != spht_pkg::RUN_TIMING)
			led_n = spht_pkg::LED_ORANGE;
		else if (!has_hit_q)
			led_n = spht_pkg::LED_WHITE;
		else
			led_n = lamp_q ? spht_pkg::LED_GREEN : spht_pkg::LED_BLUE;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			timer_state   <= run_q;
			led_color     <= led_n;
			screen        <= scr_q;
			shot_number   <= 8'(cursor_q);
			shown_time_cs <= shown_sat;
			threshold     <= thr_q;
			hit_flag      <= hit_q;
			log_full      <= full_q;
		end
	end

endmodule

// ===== rtl/stop_plate_hit_timer.sv =====
// stop_plate_hit_timer: top level of the stop plate shot timer.
// Depends on spht_pkg, spht_ctrl and spht_dp.
//
//  channel | handshake          | word
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | button_levels, sensor_sample, time_ms
//  out     | out_valid/out_stall| timer_state, led_color, screen, shot_number,
//          |                    | shown_time_cs, threshold, hit_flag, log_full
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// A poll passes the accept and load states, and also the divide-by-ten multiply state
// when it logs a hit, or the log read state when it shows a logged split.
// One poll is in flight; the next is accepted while its result word waits.
// A stalled result holds the last stage until the output register frees.
// Reset loads the default registers; the hit log has no clearing pass.
module stop_plate_hit_timer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [5:0]                      button_levels,
	input  logic [9:0]                      sensor_sample,
	input  logic [spht_pkg::TIME_BITS-1:0]  time_ms,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      timer_state,
	output logic [1:0]                      led_color,
	output logic [2:0]                      screen,
	output logic [7:0]                      shot_number,
	output logic [spht_pkg::SHOWN_W-1:0]    shown_time_cs,
	output logic [7:0]                      threshold,
	output logic                            hit_flag,
	output logic                            log_full,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic [7:0]                      cfg_data
);

	spht_pkg::spht_cmd_t cmd;
	spht_pkg::spht_sts_t sts;

	assign cfg_ready = 1'b1;

	spht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	spht_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.button_levels (button_levels),
		.sensor_sample (sensor_sample),
		.time_ms       (time_ms),
		.timer_state   (timer_state),
		.led_color     (led_color),
		.screen        (screen),
		.shot_number   (shot_number),
		.shown_time_cs (shown_time_cs),
		.threshold     (threshold),
		.hit_flag      (hit_flag),
		.log_full      (log_full)
	);

endmodule

// ===== rtl/spht_checker.sv =====
// spht_checker: port-level checks on the stop plate hit timer, bound to the top.
// Depends on spht_pkg and stop_plate_hit_timer.
module spht_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] timer_state,
	input logic [1:0] led_color,
	input logic [2:0] screen,
	input logic [7:0] shot_number,
	input logic       hit_flag,
	input logic       log_full
);

	// a word never both logs and drops a hit
	a_hit_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit_flag && log_full))
		else $error("hit_flag and log_full both set");

	// a logged hit leaves the block timing on the recording screen
	a_hit_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit_flag) |->
			(timer_state == spht_pkg::RUN_TIMING && screen == spht_pkg::SCR_RECORD
			&& shot_number != 8'd0))
		else $error("hit word with wrong state, screen or shot number");

	// lamp is orange outside timing, never orange while timing
	a_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((timer_state == spht_pkg::RUN_TIMING) == (led_color != spht_pkg::LED_ORANGE)))
		else $error("lamp color does not match state");

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(shot_number) && $stable(screen)))
		else $error("stalled result word changed");

endmodule

bind stop_plate_hit_timer spht_checker u_spht_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.timer_state (timer_state),
	.led_color   (led_color),
	.screen      (screen),
	.shot_number (shot_number),
	.hit_flag    (hit_flag),
	.log_full    (log_full)
);

// ===== tb/tb_stop_plate_hit_timer.sv =====
// tb_stop_plate_hit_timer: self-checking bench for the stop plate shot timer.
// Drives polls and register writes, mirrors the timer state in SystemVerilog and checks
// every result word in order. Depends on spht_pkg and stop_plate_hit_timer.
module tb_stop_plate_hit_timer;

	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [1:0]                   state;
		logic [1:0]                   led;
		logic [2:0]                   scr;
		logic [7:0]                   shot;
		logic [spht_pkg::SHOWN_W-1:0] shown;
		logic [7:0]                   thr;
		logic                         hit;
		logic                         full;
	} panel_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [5:0]                     button_levels = 6'h3F;
	logic [9:0]                     sensor_sample = '0;
	logic [spht_pkg::TIME_BITS-1:0] time_ms = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [1:0]                     timer_state;
	logic [1:0]                     led_color;
	logic [2:0]                     screen;
	logic [7:0]                     shot_number;
	logic [spht_pkg::SHOWN_W-1:0]   shown_time_cs;
	logic [7:0]                     threshold;
	logic                           hit_flag;
	logic                           log_full;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [1:0]                     cfg_index = '0;
	logic [7:0]                     cfg_data = '0;

	// mirrored timer state
	logic [5:0]  btn_marks = '0;
	logic [1:0]  run_st = spht_pkg::RUN_IDLE;
	logic [31:0] run_t0 = '0;
	logic        run_hit = 1'b0;
	logic [31:0] split_log [spht_pkg::LOG_DEPTH];
	int          cursor = 0;
	int          shots = 0;
	logic        lamp = 1'b0;
	logic [7:0]  thr_now = spht_pkg::THR_START_RST;
	logic [5:0]  reg_step = spht_pkg::STEP_RST;
	logic [7:0]  reg_max = spht_pkg::SENS_MAX_RST;

	panel_t      panels_due [$];
	panel_t      want_panel;
	int          mismatches = 0;
	int          stuck_cycles = 0;
	int          polls_sent = 0;
	int          gap_max = 17;
	int          stall_max = 17;
	logic [31:0] now_ms = '0;

	stop_plate_hit_timer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_levels(button_levels),
		.sensor_sample(sensor_sample),
		.time_ms      (time_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.timer_state  (timer_state),
		.led_color    (led_color),
		.screen       (screen),
		.shot_number  (shot_number),
		.shown_time_cs(shown_time_cs),
		.threshold    (threshold),
		.hit_flag     (hit_flag),
		.log_full     (log_full),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [spht_pkg::SHOWN_W-1:0] clip_shown(input logic [31:0] split);
		return (split > 32'(spht_pkg::SHOWN_MAX)) ? spht_pkg::SHOWN_MAX
			: split[spht_pkg::SHOWN_W-1:0];
	endfunction

	task automatic view_log(inout panel_t p);
		p.shown = '0;
		if (shots == 0) begin
			p.scr = spht_pkg::SCR_READY;
		end else begin
			p.scr = spht_pkg::SCR_REVIEW;
			if (cursor >= 1 && cursor <= spht_pkg::LOG_DEPTH)
				p.shown = clip_shown(split_log[cursor-1]);
		end
	endtask

	// one poll through the mirrored timer; queues the panel word it yields
	task automatic step_shot_timer(input logic [5:0] lv, input logic [9:0] smp,
		input logic [31:0] tms);
		panel_t      p;
		logic [2:0]  btn;
		logic [31:0] split;
		int          sum;
		int          i;
		btn = spht_pkg::KEY_NONE;
		// scan stops at the first release; later marks keep their value
		for (i = 0; i < 6; i++) begin
			if (btn == spht_pkg::KEY_NONE) begin
				if (!lv[i])
					btn_marks[i] = 1'b1;
				else if (btn_marks[i]) begin
					btn_marks[i] = 1'b0;
					btn = 3'(i);
				end
			end
		end
		p = '0;
		if (run_st == spht_pkg::RUN_TIMING) begin
			if (btn == spht_pkg::KEY_STOP) begin
				if (shots == 0 || !run_hit) begin
					run_st = spht_pkg::RUN_IDLE;
					p.scr = spht_pkg::SCR_READY;
				end else begin
					run_st = spht_pkg::RUN_REVIEW;
					view_log(p);
				end
			end else if (btn == spht_pkg::KEY_NONE && smp >= thr_now) begin
				if (!run_hit) begin
					run_hit = 1'b1;
					shots = 0;
					cursor = 0;
					lamp = 1'b1;
				end
				if (cursor >= spht_pkg::LOG_DEPTH) begin
					p.full = 1'b1;
				end else begin
					split = (tms - run_t0) / 32'd10;
					lamp = !lamp;
					cursor++;
					shots = cursor;
					split_log[cursor-1] = split;
					p.hit = 1'b1;
					p.scr = spht_pkg::SCR_RECORD;
					p.shown = clip_shown(split);
				end
			end
		end else begin
			if (btn == spht_pkg::KEY_START) begin
				run_st = spht_pkg::RUN_TIMING;
				run_t0 = tms;
				run_hit = 1'b0;
				p.scr = spht_pkg::SCR_RECORD;
			end else if (btn == spht_pkg::KEY_STOP) begin
				if (run_st == spht_pkg::RUN_REVIEW) begin
					run_st = spht_pkg::RUN_IDLE;
					p.scr = spht_pkg::SCR_READY;
				end else begin
					view_log(p);
					run_st = spht_pkg::RUN_REVIEW;
				end
			end else if (btn == spht_pkg::KEY_FWD && run_st == spht_pkg::RUN_REVIEW) begin
				if (cursor < shots)
					cursor++;
				view_log(p);
			end else if (btn == spht_pkg::KEY_BACK && run_st == spht_pkg::RUN_REVIEW) begin
				if (cursor > 1)
					cursor--;
				view_log(p);
			end else if (btn == spht_pkg::KEY_MORE) begin
				if (thr_now > reg_step)
					thr_now = thr_now - reg_step;
				p.scr = spht_pkg::SCR_SENSE;
			end else if (btn == spht_pkg::KEY_LESS) begin
				if (thr_now < reg_max) begin
					sum = thr_now + reg_step;
					thr_now = (sum > reg_max) ? reg_max : 8'(sum);
				end
				p.scr = spht_pkg::SCR_SENSE;
			end
		end
		if (run_st != spht_pkg::RUN_TIMING)
			p.led = spht_pkg::LED_ORANGE;
		else if (!run_hit)
			p.led = spht_pkg::LED_WHITE;
		else
			p.led = lamp ? spht_pkg::LED_GREEN : spht_pkg::LED_BLUE;
		p.state = run_st;
		p.shot = 8'(cursor);
		p.thr = thr_now;
		panels_due.push_back(p);
	endtask

	function automatic logic [31:0] next_time();
		if ($urandom_range(0, 19) == 0)
			now_ms = now_ms + $urandom;
		else
			now_ms = now_ms + $urandom_range(0, 3000);
		return now_ms;
	endfunction

	function automatic logic [9:0] hit_sample();
		case ($urandom_range(0, 3))
		0: return 10'($urandom);
		1: return {2'b00, thr_now} - 10'd1;
		2: return {2'b00, thr_now};
		default: return 10'($urandom_range(1023, thr_now));
		endcase
	endfunction

	// called right after a rising edge; returns right after the accepting edge
	task automatic send_poll(input logic [5:0] lv, input logic [9:0] smp,
		input logic [31:0] tms);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		button_levels <= lv;
		sensor_sample <= smp;
		time_ms <= tms;
		step_shot_timer(lv, smp, tms);
		polls_sent++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic tap(input logic [2:0] b, input logic [9:0] smp);
		send_poll(~(6'd1 << b), 10'd0, next_time());
		send_poll(6'h3F, smp, next_time());
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (panels_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
		spht_pkg::CFG_STEP: reg_step = val[5:0];
		spht_pkg::CFG_SENS_MAX: reg_max = val;
		spht_pkg::CFG_THR_START: thr_now = val;
		default: ;
		endcase
	endtask

	task automatic load_settings(input logic [7:0] step_v, input logic [7:0] max_v,
		input logic [7:0] start_v);
		wait_idle();
		write_reg(spht_pkg::CFG_STEP, step_v);
		write_reg(spht_pkg::CFG_SENS_MAX, max_v);
		write_reg(spht_pkg::CFG_THR_START, start_v);
		cfg_valid <= 1'b0;
	endtask

	task automatic threshold_edge_run();
		tap(spht_pkg::KEY_START, 10'd0);
		send_poll(6'h3F, {2'b00, thr_now} - 10'd1, next_time());
		send_poll(6'h3F, {2'b00, thr_now}, next_time());
		tap(spht_pkg::KEY_STOP, 10'd0);
	endtask

	task automatic test_idle_buttons();
		tap(spht_pkg::KEY_STOP, 10'd0);   // review of an empty log
		tap(spht_pkg::KEY_BACK, 10'd0);   // cursor at zero holds
		tap(spht_pkg::KEY_MORE, 10'd0);
		tap(spht_pkg::KEY_LESS, 10'd0);
		tap(spht_pkg::KEY_STOP, 10'd0);
	endtask

	task automatic test_run_and_review();
		tap(spht_pkg::KEY_START, 10'd0);
		send_poll(6'h3F, {2'b00, thr_now} - 10'd1, next_time());
		send_poll(6'h3F, {2'b00, thr_now}, next_time());
		send_poll(6'h3F, 10'd1023, next_time());
		tap(spht_pkg::KEY_FWD, 10'd1023);   // release while timing masks the sample
		send_poll(6'b111100, 10'd0, next_time());
		send_poll(6'h3F, 10'd1023, next_time());   // start wins the scan
		send_poll(6'h3F, 10'd1023, next_time());   // stop still marked
		tap(spht_pkg::KEY_BACK, 10'd0);
		tap(spht_pkg::KEY_BACK, 10'd0);
		tap(spht_pkg::KEY_FWD, 10'd0);
		tap(spht_pkg::KEY_FWD, 10'd0);
		// start near the top of the time range, then a full-range and a wrapped split
		send_poll(6'h3E, 10'd0, 32'hFFFF_FFF0);
		send_poll(6'h3F, 10'd0, 32'hFFFF_FFF0);
		send_poll(6'h3F, 10'd1023, 32'hFFFF_FFEF);
		send_poll(6'h3F, 10'd1023, 32'h0000_0000);
		now_ms = '0;
		tap(spht_pkg::KEY_STOP, 10'd0);
		tap(spht_pkg::KEY_BACK, 10'd0);
		tap(spht_pkg::KEY_START, 10'd0);
		tap(spht_pkg::KEY_STOP, 10'd0);     // no hit this run: back to idle
	endtask

	task automatic test_log_full();
		tap(spht_pkg::KEY_START, 10'd0);
		gap_max = 0;
		stall_max = 0;
		repeat (spht_pkg::LOG_DEPTH + 2) send_poll(6'h3F, 10'd1023, next_time());
		gap_max = 17;
		stall_max = 17;
		tap(spht_pkg::KEY_STOP, 10'd0);
		tap(spht_pkg::KEY_FWD, 10'd0);
		tap(spht_pkg::KEY_BACK, 10'd0);
	endtask

	task automatic test_settings_extremes();
		load_settings(8'd1, 8'd255, 8'd1);
		tap(spht_pkg::KEY_MORE, 10'd0);
		tap(spht_pkg::KEY_LESS, 10'd0);
		tap(spht_pkg::KEY_MORE, 10'd0);
		threshold_edge_run();
		load_settings(8'd50, 8'd5, 8'd255);
		tap(spht_pkg::KEY_LESS, 10'd0);
		tap(spht_pkg::KEY_MORE, 10'd0);
		tap(spht_pkg::KEY_LESS, 10'd0);
		threshold_edge_run();
		load_settings(8'd50, 8'd255, 8'd230);
		tap(spht_pkg::KEY_LESS, 10'd0);
		tap(spht_pkg::KEY_LESS, 10'd0);
		tap(spht_pkg::KEY_MORE, 10'd0);
		threshold_edge_run();
	endtask

	task automatic random_polls(input int count);
		int         last;
		int         pick;
		int         held;
		logic [2:0] b;
		last = polls_sent + count;
		while (polls_sent < last) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_poll(6'h3F, hit_sample(), next_time());
			end else if (pick < 82) begin
				pick = $urandom_range(0, 99);
				if (pick < 22)
					b = spht_pkg::KEY_START;
				else if (pick < 40)
					b = spht_pkg::KEY_STOP;
				else if (pick < 60)
					b = spht_pkg::KEY_FWD;
				else if (pick < 75)
					b = spht_pkg::KEY_BACK;
				else if (pick < 88)
					b = spht_pkg::KEY_MORE;
				else
					b = spht_pkg::KEY_LESS;
				held = $urandom_range(1, 3);
				repeat (held) send_poll(~(6'd1 << b), hit_sample(), next_time());
				send_poll(6'h3F, hit_sample(), next_time());
			end else begin
				send_poll(6'($urandom), 10'($urandom),
					($urandom_range(0, 3) == 0) ? $urandom : next_time());
			end
		end
	endtask

	task automatic test_random_sessions();
		load_settings(8'($urandom_range(1, 50)), 8'($urandom_range(5, 255)),
			8'($urandom_range(1, 255)));
		random_polls(110);
		load_settings(8'd1, 8'd255, 8'($urandom_range(1, 255)));
		gap_max = 0;
		stall_max = 0;
		random_polls(110);
		load_settings(8'd50, 8'd5, 8'($urandom_range(1, 255)));
		gap_max = 17;
		random_polls(110);
		load_settings(8'($urandom_range(1, 50)), 8'($urandom_range(5, 255)),
			8'($urandom_range(1, 255)));
		stall_max = 17;
		random_polls(110);
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%s: expected %0h, got %0h", name, want_v, got_v);
		end
	endtask

	// result word check and stall watchdog, both on pre-edge values
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (out_valid && !out_stall) begin
			if (panels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word with no poll pending");
			end else begin
				want_panel = panels_due.pop_front();
				check_field("timer_state", want_panel.state, timer_state);
				check_field("led_color", want_panel.led, led_color);
				check_field("screen", want_panel.scr, screen);
				check_field("shot_number", want_panel.shot, shot_number);
				check_field("shown_time_cs", want_panel.shown, shown_time_cs);
				check_field("threshold", want_panel.thr, threshold);
				check_field("hit_flag", want_panel.hit, hit_flag);
				check_field("log_full", want_panel.full, log_full);
			end
		end
	end

	initial begin : result_stall
		int hold;
		@(posedge clk);
		forever begin
			hold = $urandom_range(0, stall_max);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		wait (stuck_cycles >= WATCHDOG_LIMIT);
		$display("tb_stop_plate_hit_timer NOT OK");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_buttons();
		test_run_and_review();
		test_log_full();
		test_settings_extremes();
		test_random_sessions();
		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_stop_plate_hit_timer OK");
		else
			$display("tb_stop_plate_hit_timer NOT OK");
		$finish;
	end

endmodule

// ===== stop_plate_hit_timer.f =====
rtl/spht_pkg.sv
rtl/spht_ctrl.sv
rtl/spht_dp.sv
rtl/stop_plate_hit_timer.sv
rtl/spht_checker.sv
tb/tb_stop_plate_hit_timer.sv
